// File: src/oai_pkg.sv
// ----------------------------------------------------------------------------
// oai_pkg
// shared types and codes for the ordered array insert and search core
// ----------------------------------------------------------------------------
package oai_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 9;
  localparam int LOC_W   = 8;
  localparam int ENT_W   = 9;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BEYOND = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REPORT
  } state_t;

  typedef struct packed {
    logic                      ins;
    logic                      start;
    logic                      step;
    logic [POS_W-1:0]          pos;
    logic signed [VALUE_W-1:0] value;
  } cell_ctl_t;

endpackage

// File: src/ordered_array_insert_search_core.sv
// ----------------------------------------------------------------------------
// ordered_array_insert_search_core
// array of signed entries with insert at position, linear search and clear
// ----------------------------------------------------------------------------
// The array is a row of DEPTH cells, one entry each. An insert into a row that
// is not full, at a position no greater than the entry count, updates the row at
// the accepting edge, where every cell above the insert position takes its lower
// neighbour's entry at once; a clear only resets the entry count. Results of
// inserts, clears and unused codes are valid in the next cycle. A search
// compares all cells in the accept cycle, walks a token up the row one cell per
// cycle, stops at the first match or at the entry count and reports from
// S_REPORT. One item is in work at a time; the input stalls while a search walks
// the row or waits to report, and while a result sits in the output register under a stall.
module ordered_array_insert_search_core #(
  parameter int DEPTH = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_func,
  input  logic [oai_pkg::POS_W-1:0]          in_position,
  input  logic signed [oai_pkg::VALUE_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_found,
  output logic [oai_pkg::LOC_W-1:0]          out_location,
  output logic [oai_pkg::ENT_W-1:0]          out_entries,
  output logic [1:0]                         out_status
);
  import oai_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             used_r, used_nxt;
  logic [CW-1:0]             scan_r, scan_nxt;
  logic                      res_found_r, res_found_nxt;
  logic [CW-1:0]             res_loc_r, res_loc_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic                      out_found_r, out_found_nxt;
  logic [LOC_W-1:0]          out_location_r, out_location_nxt;
  logic [ENT_W-1:0]          out_entries_r, out_entries_nxt;
  logic [1:0]                out_status_r, out_status_nxt;

  logic                      accept;
  logic                      out_free;
  logic                      full;
  logic                      beyond;
  logic                      scan_end;
  logic                      any_hit;
  logic                      load_out;
  cell_ctl_t                 cell_ctl;

  logic signed [VALUE_W-1:0] data_chain [DEPTH+1];
  logic [DEPTH:0]            tok_chain;
  logic [DEPTH-1:0]          hits;

  assign out_free = !out_valid_r || !out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (used_r == CW'(DEPTH));
  assign beyond   = (PW'(in_position) > PW'(used_r));
  assign scan_end = (scan_r == used_r);
  assign any_hit  = |hits;

  // cell row
  assign data_chain[0] = '0;
  assign tok_chain[0]  = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    oai_cell #(
      .IDX(g)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl_i       (cell_ctl),
      .prev_data_i (data_chain[g]),
      .prev_tok_i  (tok_chain[g]),
      .data_o      (data_chain[g+1]),
      .tok_o       (tok_chain[g+1]),
      .hit_o       (hits[g])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_func == OP_SEARCH)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end || any_hit) begin
          state_nxt = S_REPORT;
        end
      end
      S_REPORT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_stall       = 1'b1;
    load_out       = 1'b0;
    cell_ctl.ins   = 1'b0;
    cell_ctl.start = 1'b0;
    cell_ctl.step  = 1'b0;
    cell_ctl.pos   = in_position;
    cell_ctl.value = in_value;
    unique case (state_r)
      S_IDLE: begin
        in_stall       = !out_free;
        cell_ctl.ins   = accept && (in_func == OP_INSERT) && !full && !beyond;
        cell_ctl.start = accept && (in_func == OP_SEARCH);
        load_out       = accept && (in_func != OP_SEARCH);
      end
      S_SCAN: begin
        cell_ctl.step = !scan_end && !any_hit;
      end
      S_REPORT: begin
        load_out = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // count, scan index and search result
  always_comb begin
    used_nxt      = used_r;
    scan_nxt      = scan_r;
    res_found_nxt = res_found_r;
    res_loc_nxt   = res_loc_r;
    if (cell_ctl.ins) begin
      used_nxt = used_r + CW'(1);
    end else if (accept && (in_func == OP_CLEAR)) begin
      used_nxt = '0;
    end
    if (cell_ctl.start) begin
      scan_nxt = '0;
    end else if (cell_ctl.step) begin
      scan_nxt = scan_r + CW'(1);
    end
    if (state_r == S_SCAN) begin
      res_found_nxt = !scan_end && any_hit;
      res_loc_nxt   = scan_end ? '0 : scan_r;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt    = load_out || (out_valid_r && out_stall);
    out_found_nxt    = out_found_r;
    out_location_nxt = out_location_r;
    out_entries_nxt  = out_entries_r;
    out_status_nxt   = out_status_r;
    if (load_out) begin
      if (state_r == S_REPORT) begin
        out_found_nxt    = res_found_r;
        out_location_nxt = LOC_W'(res_loc_r);
        out_entries_nxt  = ENT_W'(used_r);
        out_status_nxt   = ST_OK;
      end else begin
        out_found_nxt    = 1'b0;
        out_location_nxt = '0;
        out_entries_nxt  = ENT_W'(used_nxt);
        out_status_nxt   = ST_OK;
        if (in_func == OP_INSERT) begin
          if (full) begin
            out_status_nxt = ST_FULL;
          end else if (beyond) begin
            out_status_nxt = ST_BEYOND;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r         <= scan_nxt;
    res_found_r    <= res_found_nxt;
    res_loc_r      <= res_loc_nxt;
    out_found_r    <= out_found_nxt;
    out_location_r <= out_location_nxt;
    out_entries_r  <= out_entries_nxt;
    out_status_r   <= out_status_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_location = out_location_r;
  assign out_entries  = out_entries_r;
  assign out_status   = out_status_r;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_r <= used_r))
    else $error("scan index beyond entry count");

  a_tok_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_chain[DEPTH:1]))
    else $error("more than one search token in the row");

  a_tok_present: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && !scan_end) |-> $onehot(tok_chain[DEPTH:1]))
    else $error("search token lost during scan");

  a_report_load: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_REPORT) && out_free) |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("search result not delivered to output register");
`endif

endmodule

// File: src/oai_cell.sv
// ----------------------------------------------------------------------------
// oai_cell
// one array slot: holds an entry, shifts up on insert, carries the search token
// ----------------------------------------------------------------------------
module oai_cell #(
  parameter int IDX = 0
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  oai_pkg::cell_ctl_t                 ctl_i,
  input  logic signed [oai_pkg::VALUE_W-1:0] prev_data_i,
  input  logic                               prev_tok_i,
  output logic signed [oai_pkg::VALUE_W-1:0] data_o,
  output logic                               tok_o,
  output logic                               hit_o
);
  import oai_pkg::*;

  localparam logic [31:0] IDX_U = 32'(IDX);

  logic signed [VALUE_W-1:0] data_r, data_nxt;
  logic                      tok_r, tok_nxt;
  logic                      match_r, match_nxt;
  logic [31:0]               pos_ext;

  assign pos_ext = 32'(ctl_i.pos);

  always_comb begin
    data_nxt = data_r;
    if (ctl_i.ins) begin
      if (IDX_U == pos_ext) begin
        data_nxt = ctl_i.value;
      end else if (IDX_U > pos_ext) begin
        data_nxt = prev_data_i;
      end
    end
  end

  always_comb begin
    tok_nxt   = tok_r;
    match_nxt = match_r;
    if (ctl_i.start) begin
      tok_nxt   = (IDX_U == 32'd0);
      match_nxt = (data_r == ctl_i.value);
    end else if (ctl_i.step) begin
      tok_nxt = prev_tok_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= match_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign data_o = data_r;
  assign tok_o  = tok_r;
  assign hit_o  = tok_r & match_r;

endmodule

// File: bench/ordered_array_insert_search_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_array_insert_search_core_tb
// self-checking bench for the ordered array insert and search core
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the array and entry count, works out the
// outcome of every accepted item and compares each accepted result with the
// oldest outstanding outcome. A short directed run covers the edge cases;
// random runs then fill the array to full, build short lists with repeated
// values and mix in noise. The sender works in bursts and the receiver stalls
// on patterns of its own, including one long hold-off.
// ----------------------------------------------------------------------------
module ordered_array_insert_search_core_tb;
  import oai_pkg::*;

  localparam int          DEPTH        = 256;
  localparam int          NUM_ITEMS    = 1100;
  localparam int          IDLE_LIMIT   = 5000;
  localparam int          DRAIN_CYCLES = 300;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          HOLD_AFTER   = 300;
  localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
  localparam logic [8:0]  POS_MAX      = 9'h1FF;

  typedef struct packed {
    logic               found;
    logic [LOC_W-1:0]   location;
    logic [ENT_W-1:0]   entries;
    logic [1:0]         status;
  } outcome_t;

  class array_scoreboard;
    logic [VALUE_W-1:0] cells[DEPTH];
    int unsigned        count;
    outcome_t           outcomes_due[$];
    int                 errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function void record_item(logic [1:0] f, logic [POS_W-1:0] p, logic [VALUE_W-1:0] v);
      outcome_t o;
      int       i;
      o.found    = 1'b0;
      o.location = '0;
      o.status   = ST_OK;
      case (f)
        OP_INSERT: begin
          if (count >= DEPTH) begin
            o.status = ST_FULL;
          end else if (p > count) begin
            o.status = ST_BEYOND;
          end else begin
            for (i = count; i > p; i--) cells[i] = cells[i-1];
            cells[p] = v;
            count++;
          end
        end
        OP_SEARCH: begin
          for (i = 0; i < count && !o.found; i++) begin
            if (cells[i] == v) begin
              o.found    = 1'b1;
              o.location = i[LOC_W-1:0];
            end
          end
        end
        OP_CLEAR: count = 0;
        default: ;
      endcase
      o.entries = count[ENT_W-1:0];
      outcomes_due.push_back(o);
    endfunction

    function void check_outcome(outcome_t got);
      outcome_t want;
      if (outcomes_due.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
        return;
      end
      want = outcomes_due.pop_front();
      if (got.found !== want.found) begin
        $error("found mismatch: expected %0d, actual %0d", want.found, got.found);
        errors++;
      end
      if (got.location !== want.location) begin
        $error("location mismatch: expected %0d, actual %0d", want.location, got.location);
        errors++;
      end
      if (got.entries !== want.entries) begin
        $error("entries mismatch: expected %0d, actual %0d", want.entries, got.entries);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
    endfunction

    function int pending();
      return outcomes_due.size();
    endfunction
  endclass

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_func      = OP_CLEAR;
  logic [POS_W-1:0]     in_position  = '0;
  logic [VALUE_W-1:0]   in_value     = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic                 out_found;
  logic [LOC_W-1:0]     out_location;
  logic [ENT_W-1:0]     out_entries;
  logic [1:0]           out_status;

  array_scoreboard      sb;
  int                   accepted_in  = 0;
  int                   idle_cycles  = 0;
  int                   n_offered    = 0;
  int                   burst_left   = 1;
  int                   gen_used     = 0;
  logic [VALUE_W-1:0]   gen_pool[$];

  ordered_array_insert_search_core #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_func     (in_func),
    .in_position (in_position),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_found   (out_found),
    .out_location(out_location),
    .out_entries (out_entries),
    .out_status  (out_status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial sb = new();

  // monitors and watchdog
  always @(posedge clk) begin
    outcome_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.record_item(in_func, in_position, in_value);
        accepted_in++;
      end
      if (out_valid && !out_stall) begin
        got.found    = out_found;
        got.location = out_location;
        got.entries  = out_entries;
        got.status   = out_status;
        sb.check_outcome(got);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("ordered_array_insert_search_core test failed");
          $finish;
        end
      end
    end
  end

  // receiver stall patterns with one long hold-off
  initial begin
    int  mode;
    int  stretch;
    int  k;
    bit  held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && accepted_in >= HOLD_AFTER) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(20, 150);
      for (k = 0; k < stretch; k++) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          2: out_stall <= ($urandom_range(0, 99) < 70);
          default: out_stall <= k[0];
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0, 1: return $urandom_range(0, 15) - 8;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return '1;
          default: return '0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_search();
    if (gen_pool.size() > 0 && $urandom_range(0, 9) < 7) begin
      return gen_pool[$urandom_range(0, gen_pool.size() - 1)];
    end
    return pick_value();
  endfunction

  task automatic offer(input logic [1:0] f, input logic [POS_W-1:0] p,
                       input logic [VALUE_W-1:0] v);
    int gap;
    if (f == OP_INSERT) begin
      if (gen_used < DEPTH && p <= gen_used) begin
        gen_pool.push_back(v);
        gen_used++;
      end
    end else if (f == OP_CLEAR) begin
      gen_pool.delete();
      gen_used = 0;
    end
    in_valid    <= 1'b1;
    in_func     <= f;
    in_position <= p;
    in_value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_offered++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic fill_to_full();
    int k;
    offer(OP_CLEAR, $urandom_range(0, POS_MAX), $urandom);
    while (gen_used < DEPTH) begin
      if (gen_pool.size() > 0 && $urandom_range(0, 7) == 0) begin
        offer(OP_SEARCH, $urandom_range(0, POS_MAX), pick_search());
      end else begin
        offer(OP_INSERT, $urandom_range(0, gen_used), pick_value());
      end
    end
    offer(OP_INSERT, DEPTH, pick_value());
    offer(OP_INSERT, '0, pick_value());
    offer(OP_INSERT, $urandom_range(0, POS_MAX), pick_value());
    for (k = 0; k < 4; k++) offer(OP_SEARCH, $urandom_range(0, POS_MAX), pick_search());
    offer(OP_SEARCH, '0, $urandom);
  endtask

  task automatic short_list();
    int n;
    int k;
    int r;
    if ($urandom_range(0, 4) != 0) offer(OP_CLEAR, $urandom_range(0, POS_MAX), $urandom);
    n = $urandom_range(1, 16);
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        offer(OP_INSERT, $urandom_range(0, gen_used), pick_value());
      end else if (r == 6) begin
        offer(OP_INSERT, $urandom_range(gen_used + 1, POS_MAX), pick_value());
      end else begin
        offer(OP_SEARCH, $urandom_range(0, POS_MAX), pick_search());
      end
    end
  endtask

  task automatic noise();
    int k;
    for (k = 0; k < 8; k++) begin
      offer($urandom_range(0, 3), $urandom_range(0, POS_MAX), $urandom);
    end
  endtask

  initial begin
    int kind;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed edge cases
    offer(OP_SEARCH, '0, '0);
    offer(OP_INSERT, 9'd1, 32'h1234_5678);
    offer(OP_INSERT, POS_MAX, '1);
    offer(OP_INSERT, '0, 32'h7FFF_FFFF);
    offer(OP_INSERT, '0, 32'h8000_0000);
    offer(OP_INSERT, 9'd2, '1);
    offer(OP_INSERT, 9'd1, '0);
    offer(OP_INSERT, 9'd1, '1);
    offer(OP_SEARCH, '0, '1);
    offer(OP_SEARCH, POS_MAX, 32'h7FFF_FFFF);
    offer(OP_SEARCH, '0, 32'h8000_0000);
    offer(OP_SEARCH, '0, 32'd12345);
    offer(FUNC_UNUSED, POS_MAX, '1);
    offer(OP_INSERT, 9'd6, 32'h0F0F_0F0F);
    offer(OP_INSERT, 9'd5, 32'h5555_5555);
    offer(OP_SEARCH, '0, '0);
    offer(OP_SEARCH, '0, 32'h5555_5555);
    offer(OP_CLEAR, POS_MAX, '1);
    offer(OP_SEARCH, '0, '1);
    offer(OP_INSERT, '0, 32'hAAAA_AAAA);
    offer(OP_SEARCH, '0, 32'hAAAA_AAAA);
    offer(OP_CLEAR, '0, '0);

    // random part
    fill_to_full();
    while (n_offered < NUM_ITEMS) begin
      kind = $urandom_range(0, 11);
      if (kind == 0 && (n_offered + DEPTH + 64 <= NUM_ITEMS)) begin
        fill_to_full();
      end else if (kind < 9) begin
        short_list();
      end else begin
        noise();
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ordered_array_insert_search_core test passed");
    end else begin
      $display("ordered_array_insert_search_core test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/oai_pkg.sv
src/oai_cell.sv
src/ordered_array_insert_search_core.sv
bench/ordered_array_insert_search_core_tb.sv
